// ===== src/assert_macros.svh =====
// Assertion macros used by the palette matcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is asserted.
`define PBNC_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);

// Clocked check that must also hold while reset is asserted.
`define PBNC_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) (prop)) \
        else $error(msg);

`else

`define PBNC_ASSERT(label, clk_sig, rst_sig, prop, msg)
`define PBNC_ASSERT_ALWAYS(label, clk_sig, prop, msg)

`endif

`endif

// ===== src/pbnc_pkg.sv =====
// Package with the constants, types and helpers of the palette matcher.
package pbnc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int FRACTION_BITS   = 12;

    localparam int IDX_W    = 8;
    localparam int CNT_W    = IDX_W + 1;
    localparam int ADDR_W   = $clog2(PALETTE_ENTRIES);
    localparam int COMP_W   = 8;
    localparam int RGB_W    = 3 * COMP_W;
    localparam int SS_W     = 18;
    localparam int ENTRY_W  = RGB_W + SS_W;

    localparam int PCT_W     = 7;
    localparam int PCT_MAX   = 100;
    localparam int PCT_RESET = 66;

    localparam int WEIGHT_W = FRACTION_BITS + 1;
    localparam int MIX_W    = COMP_W + FRACTION_BITS;
    localparam int BLEND_W  = COMP_W + WEIGHT_W + 2;
    localparam int PROD_W   = COMP_W + MIX_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int TOT_W    = SS_W + FRACTION_BITS - 1;
    localparam int SCORE_W  = DOT_W + 1;

    // Reciprocal of the percent divisor, exact for every scaled percent.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 20;
    localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + PCT_MAX - 1) / PCT_MAX;
    localparam int SCALED_W    = PCT_W + FRACTION_BITS;
    localparam int RECIP_P_W   = SCALED_W + RECIP_W;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [1:0] LAST_COMP = 2'd2;

    typedef enum logic
    {
        REQ_WRITE,
        REQ_QUERY
    } req_type_t;

    typedef enum logic
    {
        MIX_BLEND,
        MIX_SUBTRACT
    } mix_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_MIX_MODE,
        CFG_BLEND_PERCENT
    } cfg_reg_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_WRITE,
        ST_READ_ROW,
        ST_READ_COL,
        ST_WEIGHT,
        ST_MIX,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef logic [2:0][MIX_W-1:0] mix_vec_t;

    typedef struct packed
    {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
        logic [SS_W-1:0]  ss;
    } entry_t;

    typedef struct packed
    {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic signed [SCORE_W-1:0] score;
    } score_t;

    typedef struct packed
    {
        logic busy;
    } unit_status_t;

    // Component zero is red, one is green, two is blue.
    function automatic logic [COMP_W-1:0] comp_of(input logic [RGB_W-1:0] rgb,
                                                  input logic [1:0] k);
        logic [COMP_W-1:0] value;
        case (k)
            2'd0:    value = rgb[3*COMP_W-1:2*COMP_W];
            2'd1:    value = rgb[2*COMP_W-1:COMP_W];
            default: value = rgb[COMP_W-1:0];
        endcase
        return value;
    endfunction

endpackage

// ===== src/pbnc_cfg_if.sv =====
// Configuration write channel of the palette matcher.
interface pbnc_cfg_if;
    import pbnc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/pbnc_req_if.sv =====
// Request channel of the palette matcher: palette writes and queries.
interface pbnc_req_if;
    import pbnc_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [COMP_W-1:0] entry_red;
    logic [COMP_W-1:0] entry_green;
    logic [COMP_W-1:0] entry_blue;
    logic [IDX_W-1:0]  row_color;
    logic [IDX_W-1:0]  column_color;

    modport source (output valid, output req_type, output entry_index,
                    output entry_red, output entry_green, output entry_blue,
                    output row_color, output column_color, input ready);
    modport sink (input valid, input req_type, input entry_index,
                  input entry_red, input entry_green, input entry_blue,
                  input row_color, input column_color, output ready);
endinterface

// ===== src/pbnc_res_if.sv =====
// Result channel of the palette matcher.
interface pbnc_res_if;
    import pbnc_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] match_index;

    modport source (output valid, output match_index, input ready);
    modport sink (input valid, input match_index, output ready);
endinterface

// ===== src/pbnc_ram.sv =====
// Generic single write port RAM with one registered read port.
module pbnc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pbnc_score_unit.sv =====
// Two stage score unit: scaled square sum minus the dot product with the mix.
module pbnc_score_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbnc_pkg::mix_mode_t    mode,
    input  pbnc_pkg::mix_vec_t     mix,
    input  pbnc_pkg::entry_t       entry,
    output pbnc_pkg::score_t       result,
    output pbnc_pkg::unit_status_t status
);
    import pbnc_pkg::*;

    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [PROD_W-1:0] prod_reg [3];
    logic [TOT_W-1:0]  tot_reg;

    logic                      s2_valid_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic signed [SCORE_W-1:0] score_reg;

    logic [DOT_W-1:0]          dot;
    logic signed [SCORE_W-1:0] score_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= entry.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= entry.idx;
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= PROD_W'(comp_of(entry.rgb, 2'(k))) * PROD_W'(mix[k]);
        end
        if (mode == MIX_BLEND)
        begin
            tot_reg <= TOT_W'(entry.ss) << (FRACTION_BITS - 1);
        end
        else
        begin
            tot_reg <= TOT_W'(entry.ss >> 1);
        end
        s2_idx_reg <= s1_idx_reg;
        score_reg  <= score_next;
    end

    always_comb
    begin
        dot = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
        score_next = $signed(SCORE_W'(tot_reg)) - $signed(SCORE_W'(dot));
    end

    assign result.valid = s2_valid_reg;
    assign result.idx   = s2_idx_reg;
    assign result.score = score_reg;
    assign status.busy  = s1_valid_reg | s2_valid_reg;

endmodule

// ===== src/palette_blend_nearest_color.sv =====
// Top level of the palette blend nearest color matcher.
// The block holds a palette in one RAM and answers queries with the index of
// the entry that best matches a mix of two palette colors. A write word loads
// one entry. A query word reads the row and column colors, forms the weight
// and the mix one component per cycle, and then scans every entry from the
// highest index down, one entry per cycle through the RAM read port and the
// score pipeline, and only then offers its result word. The result sits in
// an output register, so a new word is taken while it waits. Entries read
// as black until written: per-entry valid bits are cleared by reset, and no
// clearing pass is needed. Configuration is taken at any time.
`include "assert_macros.svh"

module palette_blend_nearest_color (
    input logic        clk,
    input logic        rst_n,
    pbnc_cfg_if.sink   cfg,
    pbnc_req_if.sink   req,
    pbnc_res_if.source res
);
    import pbnc_pkg::*;

    state_t state_reg;
    state_t state_next;

    mix_mode_t        mix_mode_reg;
    logic [PCT_W-1:0] pct_reg;

    logic [IDX_W-1:0]  idx_reg;
    logic [COMP_W-1:0] red_reg;
    logic [COMP_W-1:0] green_reg;
    logic [COMP_W-1:0] blue_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;

    logic [RGB_W-1:0]    row_rgb_reg;
    logic [RGB_W-1:0]    col_rgb_reg;
    logic [WEIGHT_W-1:0] w1_reg;
    mix_vec_t            mix_reg;
    logic [1:0]          comp_reg;
    logic [IDX_W-1:0]    scan_reg;

    logic [PALETTE_ENTRIES-1:0] loaded_reg;
    logic                       rd_loaded_reg;
    logic                       rd_tag_reg;
    logic [IDX_W-1:0]           rd_idx_reg;

    logic                      have_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic [IDX_W-1:0]          best_idx_reg;

    logic             res_valid_reg;
    logic [IDX_W-1:0] res_index_reg;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] rd_index;
    logic             issue;
    logic             load_res;
    logic             rd_in_range;
    logic             entry_fits;
    logic [SS_W-1:0]  ss_calc;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] rd_entry;

    logic [PCT_W-1:0]     pct_sat;
    logic [RECIP_P_W-1:0] recip_prod;
    logic [WEIGHT_W-1:0]  w1_calc;

    logic [COMP_W-1:0]         row_c;
    logic [COMP_W-1:0]         col_c;
    logic signed [BLEND_W-1:0] diff_s;
    logic signed [BLEND_W-1:0] weight_s;
    logic signed [BLEND_W-1:0] blend_sum;
    logic [MIX_W-1:0]          mix_calc;

    entry_t       unit_entry;
    score_t       unit_result;
    unit_status_t unit_status;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.req_type == REQ_QUERY) ? ST_READ_ROW : ST_WRITE;
                end
            end
            ST_WRITE:    state_next = ST_IDLE;
            ST_READ_ROW: state_next = ST_READ_COL;
            ST_READ_COL: state_next = ST_WEIGHT;
            ST_WEIGHT:   state_next = ST_MIX;
            ST_MIX:
            begin
                if (comp_reg == LAST_COMP)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_tag_reg && !unit_status.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        rd_index  = scan_reg;
        issue     = 1'b0;
        load_res  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_WRITE: ram_we = entry_fits;
            ST_READ_ROW:
            begin
                ram_re   = 1'b1;
                rd_index = row_reg;
            end
            ST_READ_COL:
            begin
                ram_re   = 1'b1;
                rd_index = col_reg;
            end
            ST_SCAN:
            begin
                ram_re = 1'b1;
                issue  = 1'b1;
            end
            ST_FINISH: load_res = !res_valid_reg || res.ready;
            default:   ;
        endcase
    end

    assign entry_fits  = {1'b0, idx_reg} < CNT_W'(PALETTE_ENTRIES);
    assign rd_in_range = {1'b0, rd_index} < CNT_W'(PALETTE_ENTRIES);
    assign ss_calc     = SS_W'(red_reg) * SS_W'(red_reg)
                       + SS_W'(green_reg) * SS_W'(green_reg)
                       + SS_W'(blue_reg) * SS_W'(blue_reg);
    assign rd_entry    = rd_loaded_reg ? ram_rdata : '0;

    always_comb
    begin
        pct_sat    = (pct_reg > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct_reg;
        recip_prod = RECIP_P_W'({pct_sat, {FRACTION_BITS{1'b0}}})
                   * RECIP_P_W'(RECIP_MULT);
        w1_calc    = recip_prod[RECIP_SHIFT +: WEIGHT_W];
    end

    // The blend is row * (1 - w1) + column * w1, written as one product.
    always_comb
    begin
        row_c     = comp_of(row_rgb_reg, comp_reg);
        col_c     = comp_of(col_rgb_reg, comp_reg);
        diff_s    = BLEND_W'($signed({1'b0, col_c}) - $signed({1'b0, row_c}));
        weight_s  = $signed(BLEND_W'(w1_reg));
        blend_sum = $signed(BLEND_W'({row_c, {FRACTION_BITS{1'b0}}}))
                  + diff_s * weight_s;
        if (mix_mode_reg == MIX_BLEND)
        begin
            mix_calc = blend_sum[MIX_W-1:0];
        end
        else if (row_c > col_c)
        begin
            mix_calc = MIX_W'(row_c - col_c);
        end
        else
        begin
            mix_calc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mix_mode_reg  <= MIX_BLEND;
            pct_reg       <= PCT_W'(PCT_RESET);
            loaded_reg    <= '0;
            rd_loaded_reg <= 1'b0;
            rd_tag_reg    <= 1'b0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    CFG_MIX_MODE:      mix_mode_reg <= mix_mode_t'(cfg.data[0]);
                    CFG_BLEND_PERCENT: pct_reg <= cfg.data[PCT_W-1:0];
                    default:           ;
                endcase
            end
            if (ram_we)
            begin
                loaded_reg[idx_reg[ADDR_W-1:0]] <= 1'b1;
            end
            rd_loaded_reg <= ram_re && rd_in_range && loaded_reg[rd_index[ADDR_W-1:0]];
            rd_tag_reg    <= issue;
            if (state_reg == ST_WEIGHT)
            begin
                have_reg <= 1'b0;
            end
            else if (unit_result.valid && (!have_reg || unit_result.score < best_reg))
            begin
                have_reg <= 1'b1;
            end
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            idx_reg   <= req.entry_index;
            red_reg   <= req.entry_red;
            green_reg <= req.entry_green;
            blue_reg  <= req.entry_blue;
            row_reg   <= req.row_color;
            col_reg   <= req.column_color;
        end
        if (state_reg == ST_READ_COL)
        begin
            row_rgb_reg <= rd_entry[ENTRY_W-1:SS_W];
        end
        if (state_reg == ST_WEIGHT)
        begin
            col_rgb_reg <= rd_entry[ENTRY_W-1:SS_W];
            w1_reg      <= w1_calc;
            comp_reg    <= '0;
        end
        if (state_reg == ST_MIX)
        begin
            mix_reg[comp_reg] <= mix_calc;
            comp_reg          <= comp_reg + 2'd1;
            scan_reg          <= IDX_W'(PALETTE_ENTRIES - 1);
        end
        if (state_reg == ST_SCAN)
        begin
            scan_reg <= scan_reg - 1'b1;
        end
        rd_idx_reg <= scan_reg;
        if (unit_result.valid && (!have_reg || unit_result.score < best_reg))
        begin
            best_reg     <= unit_result.score;
            best_idx_reg <= unit_result.idx;
        end
        if (load_res)
        begin
            res_index_reg <= best_idx_reg;
        end
    end

    pbnc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES),
        .ADDR_W(ADDR_W)
    ) u_palette_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx_reg[ADDR_W-1:0]),
        .wdata({red_reg, green_reg, blue_reg, ss_calc}),
        .re   (ram_re),
        .raddr(rd_index[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign unit_entry.valid = rd_tag_reg;
    assign unit_entry.idx   = rd_idx_reg;
    assign unit_entry.rgb   = rd_entry[ENTRY_W-1:SS_W];
    assign unit_entry.ss    = rd_entry[SS_W-1:0];

    pbnc_score_unit u_score_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .mode  (mix_mode_reg),
        .mix   (mix_reg),
        .entry (unit_entry),
        .result(unit_result),
        .status(unit_status)
    );

    assign res.valid       = res_valid_reg;
    assign res.match_index = res_index_reg;

    `PBNC_ASSERT(a_score_only_in_scan, clk, rst_n, unit_result.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN), "Score word outside a palette scan.")
    `PBNC_ASSERT(a_best_before_finish, clk, rst_n, (state_reg == ST_FINISH) |-> have_reg, "Query finished without a best entry.")
    `PBNC_ASSERT(a_result_from_finish, clk, rst_n, $rose(res.valid) |-> ($past(state_reg) == ST_FINISH), "Result word raised outside the finish step.")
    `PBNC_ASSERT_ALWAYS(a_scan_in_range, clk, (state_reg != ST_SCAN) || ({1'b0, scan_reg} < CNT_W'(PALETTE_ENTRIES)), "Scan index beyond the palette.")

endmodule
